[design/clint_pkg.sv]
`default_nettype none

package clint_pkg;

    localparam int MAX_HARTS = 8;
    localparam int HART_W    = $clog2(MAX_HARTS);
    localparam int NHART_W   = 4;   // width of the harts-present count
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] SOFT_END  = 16'h4000;
    localparam logic [15:0] TIMER_OFF = 16'hbff8;

    // bus action codes
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    // config register indexes
    localparam logic REG_HART_COUNT = 1'b0;
    localparam logic REG_TICK_DIV   = 1'b1;

    // classified operation handed from front to back
    typedef enum logic [3:0] {
        OP_NONE,      // no read data, no state change
        OP_RD_ZERO,   // valid read of an absent hart
        OP_RD_SOFT,
        OP_RD_TIMER,
        OP_RD_CMP,
        OP_WR_SOFT,
        OP_WR_TIMER,
        OP_WR_CMP,
        OP_UPDATE,    // 8-byte write to absent hart: only refresh timer irqs
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [HART_W-1:0]  hart;
        logic [3:0]         len;
        logic [63:0]        data;
        logic [DIV_W-1:0]   advance;
    } t_cmd;

    // keep the low len bytes; len of 8 or more keeps all
    function automatic logic [63:0] trunc_bytes(input logic [63:0] v, input logic [3:0] len);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[b*8 +: 8] = (4'(b) < len) ? 8'hff : 8'h00;
        end
        return v & m;
    endfunction

endpackage

`default_nettype wire

[design/clint_if.sv]
`default_nettype none

interface clint_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] offset;
    logic [3:0]  access_length;
    logic [63:0] write_data;
    logic [15:0] advance;

    modport source(output valid, action, offset, access_length, write_data, advance,
                   input ready);
    modport sink(input valid, action, offset, access_length, write_data, advance,
                 output ready);
endinterface

interface clint_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic        read_valid;
    logic [7:0]  soft_pending;
    logic [7:0]  timer_pending;

    modport source(output valid, read_data, read_valid, soft_pending, timer_pending,
                   input ready);
    modport sink(input valid, read_data, read_valid, soft_pending, timer_pending,
                 output ready);
endinterface

`default_nettype wire

[design/clint_front.sv]
`default_nettype none

module clint_front (
    clint_req_if.sink                        i_req,
    input  wire logic [clint_pkg::NHART_W-1:0] i_harts,
    input  wire logic                        i_full,
    output logic                             o_push,
    output clint_pkg::t_cmd                  o_cmd
);
    import clint_pkg::*;

    logic [11:0] w_soft_idx;
    logic [15:0] w_rel;
    logic [12:0] w_cmp_idx;
    logic        w_soft_ok;
    logic        w_cmp_ok;
    logic        w_is_soft;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        w_soft_idx = i_req.offset[13:2];
        w_rel      = i_req.offset - SOFT_END;
        w_cmp_idx  = w_rel[15:3];
        w_soft_ok  = w_soft_idx < 12'(i_harts);
        w_cmp_ok   = w_cmp_idx < 13'(i_harts);
        w_is_soft  = i_req.offset < SOFT_END;

        o_cmd.op      = OP_NONE;
        o_cmd.hart    = '0;
        o_cmd.len     = i_req.access_length;
        o_cmd.data    = i_req.write_data;
        o_cmd.advance = i_req.advance;

        unique case (t_action'(i_req.action))
            ACT_READ: begin
                if (w_is_soft) begin
                    if (i_req.offset[1:0] == 2'b00) begin
                        o_cmd.op   = w_soft_ok ? OP_RD_SOFT : OP_RD_ZERO;
                        o_cmd.hart = w_soft_idx[HART_W-1:0];
                    end
                end else if (i_req.offset == TIMER_OFF) begin
                    o_cmd.op = OP_RD_TIMER;
                end else if (i_req.offset[2:0] == 3'b000) begin
                    o_cmd.op   = w_cmp_ok ? OP_RD_CMP : OP_RD_ZERO;
                    o_cmd.hart = w_cmp_idx[HART_W-1:0];
                end
            end
            ACT_WRITE: begin
                if (w_is_soft) begin
                    if (i_req.offset[1:0] == 2'b00 && i_req.access_length >= 4'd4
                            && w_soft_ok) begin
                        o_cmd.op   = OP_WR_SOFT;
                        o_cmd.hart = w_soft_idx[HART_W-1:0];
                    end
                end else if (i_req.access_length == 4'd8) begin
                    // index rounds down: misaligned compare writes still land
                    if (i_req.offset == TIMER_OFF) begin
                        o_cmd.op = OP_WR_TIMER;
                    end else if (w_cmp_ok) begin
                        o_cmd.op   = OP_WR_CMP;
                        o_cmd.hart = w_cmp_idx[HART_W-1:0];
                    end else begin
                        o_cmd.op = OP_UPDATE;
                    end
                end
            end
            ACT_TICK: begin
                o_cmd.op = OP_TICK;
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/clint_queue.sv]
`default_nettype none

module clint_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire clint_pkg::t_cmd i_push_cmd,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output clint_pkg::t_cmd      o_pop_cmd
);
    import clint_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full    = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty   = r_count == '0;
    assign o_pop_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[design/clint_back.sv]
`default_nettype none

module clint_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [clint_pkg::NHART_W-1:0] i_harts,
    input  wire logic [clint_pkg::DIV_W-1:0]   i_div,
    input  wire logic                          i_empty,
    input  wire clint_pkg::t_cmd               i_cmd,
    output logic                               o_pop,
    clint_rsp_if.source                        o_rsp
);
    import clint_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADD,
        S_CMP,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [MAX_HARTS-1:0]  r_soft;
    logic [63:0]           r_cmp [MAX_HARTS];
    logic [63:0]           r_timer;
    logic [MAX_HARTS-1:0]  r_irq;
    logic [DIV_W-1:0]      r_quo;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_CNT_W-1:0]  r_cnt;

    logic                  r_out_valid;
    logic [63:0]           r_out_data;
    logic                  r_out_rvalid;
    logic [7:0]            r_out_soft;
    logic [7:0]            r_out_timer;

    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_immediate;
    logic [MAX_HARTS-1:0]  w_mask;
    logic [MAX_HARTS-1:0]  w_irq;
    logic [MAX_HARTS-1:0]  w_soft_new;
    logic [63:0]           w_rd_data;
    logic                  w_rd_valid;
    logic [DIV_W:0]        w_rem_sh;
    logic                  w_ge;
    logic [DIV_W-1:0]      w_rem_nx;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_out_data;
    assign o_rsp.read_valid    = r_out_rvalid;
    assign o_rsp.soft_pending  = r_out_soft;
    assign o_rsp.timer_pending = r_out_timer;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign o_pop      = (r_state == S_IDLE) && !i_empty && w_out_free;
    // output register takes a new result this cycle
    assign w_out_load = (o_pop && w_immediate) || ((r_state == S_OUT) && w_out_free);

    // restoring divide, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, i_div};
    assign w_rem_nx = w_ge ? DIV_W'(w_rem_sh - {1'b0, i_div}) : w_rem_sh[DIV_W-1:0];

    always_comb begin
        for (int h = 0; h < MAX_HARTS; h++) begin
            w_mask[h] = NHART_W'(h) < i_harts;
            w_irq[h]  = w_mask[h] && (r_timer >= r_cmp[h]);
        end

        w_soft_new = r_soft;
        if (i_cmd.op == OP_WR_SOFT) begin
            w_soft_new[i_cmd.hart] = i_cmd.data[0];
        end

        w_immediate = 1'b1;
        w_rd_valid  = 1'b0;
        w_rd_data   = '0;
        case (i_cmd.op)
            OP_RD_ZERO: begin
                w_rd_valid = 1'b1;
            end
            OP_RD_SOFT: begin
                w_rd_valid = 1'b1;
                w_rd_data  = trunc_bytes(64'(r_soft[i_cmd.hart]), i_cmd.len);
            end
            OP_RD_TIMER: begin
                w_rd_valid = 1'b1;
                w_rd_data  = trunc_bytes(r_timer, i_cmd.len);
            end
            OP_RD_CMP: begin
                w_rd_valid = 1'b1;
                w_rd_data  = trunc_bytes(r_cmp[i_cmd.hart], i_cmd.len);
            end
            OP_WR_TIMER, OP_WR_CMP, OP_UPDATE, OP_TICK: begin
                w_immediate = 1'b0;
            end
            default: begin
                w_immediate = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_soft      <= '0;
            r_timer     <= '0;
            r_irq       <= '0;
            for (int h = 0; h < MAX_HARTS; h++) begin
                r_cmp[h] <= '1;
            end
        end else begin
            if (o_rsp.valid && o_rsp.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.op)
                            OP_WR_SOFT: begin
                                r_soft <= w_soft_new;
                            end
                            OP_WR_TIMER: begin
                                r_timer <= i_cmd.data;
                                r_state <= S_CMP;
                            end
                            OP_WR_CMP: begin
                                r_cmp[i_cmd.hart] <= i_cmd.data;
                                r_state           <= S_CMP;
                            end
                            OP_UPDATE: begin
                                r_state <= S_CMP;
                            end
                            OP_TICK: begin
                                r_quo   <= i_cmd.advance;
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DIV;
                            end
                            default: begin
                            end
                        endcase
                        if (w_immediate) begin
                            r_out_valid  <= 1'b1;
                            r_out_data   <= w_rd_data;
                            r_out_rvalid <= w_rd_valid;
                            r_out_soft   <= 8'(w_soft_new & w_mask);
                            r_out_timer  <= 8'(r_irq & w_mask);
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_nx;
                    r_quo <= {r_quo[DIV_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_timer <= r_timer + 64'(r_quo);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_irq   <= w_irq;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= '0;
                        r_out_rvalid <= 1'b0;
                        r_out_soft   <= 8'(r_soft & w_mask);
                        r_out_timer  <= 8'(r_irq & w_mask);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/core_local_interruptor.sv]
// Core-local interruptor: soft bits, per-hart 64-bit compares and a 64-bit timer.
// With the back idle, reads, soft writes and no-op requests go from the queue into
// the output register; timer/compare writes pass through the compare and output
// states; a tick first runs the bit-serial divider for advance / tick divider and
// adds the quotient to the timer. The back takes one request at a time, the queue
// holds two more. Synchronous active-low reset clears timer, soft, irq bits.
`default_nettype none

module core_local_interruptor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    clint_req_if.sink        i_req,
    clint_rsp_if.source      o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import clint_pkg::*;

    // config registers; compares reset to all ones in the back
    logic [3:0]         r_hart_count;
    logic [DIV_W-1:0]   r_tick_div;

    // effective values: hart count clamped, zero divider acts as one
    logic [NHART_W-1:0] w_harts;
    logic [DIV_W-1:0]   w_div;

    // front -> queue -> back
    logic               w_push;
    t_cmd               w_push_cmd;
    logic               w_full;
    logic               w_empty;
    logic               w_pop;
    t_cmd               w_pop_cmd;

    assign pready = 1'b1;

    // register select is paddr[2]: hart_count at 0, tick divider at 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hart_count <= 4'd8;
            r_tick_div   <= DIV_W'(1);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HART_COUNT) begin
                r_hart_count <= pwdata[3:0];
            end else begin
                r_tick_div <= pwdata[DIV_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TICK_DIV) ? 32'(r_tick_div)
                                               : 32'(r_hart_count);

    assign w_harts = (r_hart_count > NHART_W'(MAX_HARTS)) ? NHART_W'(MAX_HARTS)
                                                          : r_hart_count;
    assign w_div   = (r_tick_div == '0) ? DIV_W'(1) : r_tick_div;

    // front: request handshake and address decode
    clint_front u_front (
        .i_req   (i_req),
        .i_harts (w_harts),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // two-entry queue lets a new request in while the back is busy or stalled
    clint_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_empty    (w_empty),
        .o_pop_cmd  (w_pop_cmd)
    );

    // back: state, divider, compare update and the output register
    clint_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_harts (w_harts),
        .i_div   (w_div),
        .i_empty (w_empty),
        .i_cmd   (w_pop_cmd),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
